### hw/rtl/satl_pkg.sv
// Package for the shadow atlas tile allocator.
// Holds command and status codes, field widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package satl_pkg;

  localparam int CMD_W      = 2;
  localparam int LIGHT_ID_W = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int TILE_X_W   = 14;
  localparam int TILE_Y_W   = 14;
  localparam int EXT_W      = 10;
  localparam int ATLAS_W    = 15;

  localparam int TILE_PAD = 2;

  localparam logic [ATLAS_W-1:0] ATLAS_RESET = 15'd4096;

  localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // capture a new item and restart the scan
    logic scan_en;  // advance the table scan by one entry
    logic finish;   // apply the final table update and load the result
  } satl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every used entry has been compared
    logic hit;        // lookup matched the entry being compared
    logic out_free;   // result register can take a new result this cycle
  } satl_stat_t;

endpackage

`default_nettype wire

### hw/rtl/satl_ctrl.sv
// Controller state machine of the shadow atlas tile allocator.
// Depends on satl_pkg for the command and status structs and command codes.
`default_nettype none

module satl_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [satl_pkg::CMD_W-1:0]     cmd,
  output logic                                in_stall,
  input  wire satl_pkg::satl_stat_t           sts,
  output satl_pkg::satl_cmd_t                 ctl
);
  import satl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctl         = '0;
    in_stall    = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.start = 1'b1;
          // Only lookups and releases need to walk the table.
          if (cmd inside {CMD_GET, CMD_REL}) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (sts.hit || sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/satl_datapath.sv
// Datapath of the shadow atlas tile allocator: key memory, scan pipeline,
// tile position walker and result register. Depends on satl_pkg.
`default_nettype none

module satl_datapath #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int TILE_SIZE   = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire satl_pkg::satl_cmd_t                ctl,
  output satl_pkg::satl_stat_t                    sts,
  input  wire logic [satl_pkg::CMD_W-1:0]         cmd,
  input  wire logic [satl_pkg::LIGHT_ID_W-1:0]    light_id,
  input  wire logic [satl_pkg::ATLAS_W-1:0]       atlas_width,
  input  wire logic                               out_stall,
  output logic                                    out_valid,
  output logic [satl_pkg::STATUS_W-1:0]           status,
  output logic [satl_pkg::SLOT_W-1:0]             slot,
  output logic [satl_pkg::TILE_X_W-1:0]           tile_x,
  output logic [satl_pkg::TILE_Y_W-1:0]           tile_y,
  output logic [satl_pkg::EXT_W-1:0]              tile_extent
);
  import satl_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int KW = (KEY_BITS < LIGHT_ID_W) ? KEY_BITS : LIGHT_ID_W;
  localparam int XW = 17;

  localparam logic [CW-1:0]       MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [XW-1:0]       STEP_X  = XW'(TILE_SIZE);
  localparam logic [TILE_Y_W-1:0] STEP_Y  = TILE_Y_W'(TILE_SIZE);
  localparam logic [TILE_X_W-1:0] PAD_X   = TILE_X_W'(TILE_PAD);
  localparam logic [TILE_Y_W-1:0] PAD_Y   = TILE_Y_W'(TILE_PAD);
  localparam logic [EXT_W-1:0]    EXTENT  = EXT_W'(TILE_SIZE - 2 * TILE_PAD);

  logic [KW-1:0]       mem [MAX_ENTRIES];
  logic [KW-1:0]       rd_data;
  logic [CMD_W-1:0]    cmd_q;
  logic [KW-1:0]       key_q;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ridx;
  logic [IW-1:0]       cidx;
  logic                cvalid;
  logic [CW-1:0]       wptr;
  logic                found;
  logic [IW-1:0]       found_idx;
  logic [XW-1:0]       col_x;
  logic [TILE_Y_W-1:0] row_y;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [KW-1:0]       mem_wdata;
  logic                rd_en;
  logic                match;
  logic                hit;
  logic                walk;
  logic                fin_go;
  logic [XW-1:0]       nx;
  logic                wrap;

  logic [CW-1:0]       count_next;
  logic [STATUS_W-1:0] status_next;
  logic [IW-1:0]       slot_idx;
  logic                tile_en;
  logic [IW+3:0]       slot_ext;

  assign match  = (rd_data == key_q);
  assign hit    = cvalid && (cmd_q == CMD_GET) && match;
  assign rd_en  = ctl.scan_en && (ridx < count);
  assign walk   = ctl.scan_en && cvalid && (cmd_q == CMD_GET) && !match;
  assign fin_go = ctl.finish && sts.out_free;

  assign sts.scan_done = !(ridx < count) && !cvalid;
  assign sts.hit       = hit;
  assign sts.out_free  = !out_valid || !out_stall;

  // Next tile to the right, or the start of the next row when it would not fit.
  assign nx   = col_x + STEP_X;
  assign wrap = (nx + STEP_X) > XW'(atlas_width);

  // One write port: compaction during a release scan, append at the end of a lookup.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr[IW-1:0];
    mem_wdata = rd_data;
    if (ctl.scan_en && cvalid && (cmd_q == CMD_REL) && !match) begin
      mem_we = 1'b1;
    end else if (fin_go && (cmd_q == CMD_GET) && !found && (count < MAX_CNT)) begin
      mem_we    = 1'b1;
      mem_waddr = count[IW-1:0];
      mem_wdata = key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[ridx[IW-1:0]];
    end
  end

  // Final table update and result selection.
  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    slot_idx    = '0;
    tile_en     = 1'b0;
    case (cmd_q)
      CMD_GET: begin
        if (found) begin
          status_next = ST_FOUND;
          slot_idx    = found_idx;
          tile_en     = 1'b1;
        end else if (count >= MAX_CNT) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_NEW;
          slot_idx    = count[IW-1:0];
          tile_en     = 1'b1;
          count_next  = count + CW'(1);
        end
      end
      CMD_REL: begin
        count_next = wptr;
      end
      CMD_CLR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign slot_ext = {4'b0000, slot_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.start) begin
        cvalid <= 1'b0;
      end else if (ctl.scan_en) begin
        cvalid <= rd_en;
      end
      if (fin_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_q <= cmd;
      key_q <= light_id[KW-1:0];
      ridx  <= '0;
      wptr  <= '0;
      found <= 1'b0;
      col_x <= '0;
      row_y <= '0;
    end else if (ctl.scan_en) begin
      if (rd_en) begin
        ridx <= ridx + CW'(1);
        cidx <= ridx[IW-1:0];
      end
      if (hit) begin
        found     <= 1'b1;
        found_idx <= cidx;
      end
      if (ctl.scan_en && cvalid && (cmd_q == CMD_REL) && !match) begin
        wptr <= wptr + CW'(1);
      end
      if (walk) begin
        if (wrap) begin
          col_x <= '0;
          row_y <= row_y + STEP_Y;
        end else begin
          col_x <= nx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      status <= status_next;
      slot   <= slot_ext[SLOT_W-1:0];
      if (tile_en) begin
        tile_x      <= col_x[TILE_X_W-1:0] + PAD_X;
        tile_y      <= row_y + PAD_Y;
        tile_extent <= EXTENT;
      end else begin
        tile_x      <= '0;
        tile_y      <= '0;
        tile_extent <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/shadow_atlas_tile_allocator.sv
// Shadow atlas tile allocator: top level with the atlas width register.
// Depends on satl_pkg, satl_ctrl and satl_datapath.
//
// Usage: each transfer on the input channel (cmd, light_id) produces exactly one
// transfer on the output channel (status, slot, tile_x, tile_y, tile_extent).
// A lookup returns the slot of a stored key, or appends the key and returns its
// new slot, or reports a full table. A release removes every copy of the key and
// closes the gaps in order; a clear empties the table. Found and newly allocated
// slots come with the padded tile position in the atlas.
// Timing: one item is handled at a time. A lookup or release scans the used
// entries one per cycle through the key memory read port; a lookup that hits
// stops early, and a clear skips the scan. The tile position is stepped
// alongside the scan rather than in a step of its own. The result sits in an
// output register; the next input can be taken while it waits, but if the
// receiver stalls the block holds its finished work and stops accepting until
// the previous result has been transferred. Reset empties the table and sets
// the atlas width to 4096. The width register is written through cfg_wr_en
// and cfg_wr_data, only while the block is idle; the user must ensure this,
// as the block itself does not enforce it.
`default_nettype none

module shadow_atlas_tile_allocator #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int TILE_SIZE   = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [satl_pkg::ATLAS_W-1:0]       cfg_wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [satl_pkg::CMD_W-1:0]         cmd,
  input  wire logic [satl_pkg::LIGHT_ID_W-1:0]    light_id,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [satl_pkg::STATUS_W-1:0]           status,
  output logic [satl_pkg::SLOT_W-1:0]             slot,
  output logic [satl_pkg::TILE_X_W-1:0]           tile_x,
  output logic [satl_pkg::TILE_Y_W-1:0]           tile_y,
  output logic [satl_pkg::EXT_W-1:0]              tile_extent
);
  import satl_pkg::*;

  // Atlas width in pixels; the number of tile columns follows from it.
  logic [ATLAS_W-1:0] atlas_width;

  satl_cmd_t  ctl;
  satl_stat_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width <= ATLAS_RESET;
    end else if (cfg_wr_en) begin
      atlas_width <= cfg_wr_data;
    end
  end

  // The controller sequences start, scan and finish for each item.
  satl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // The datapath holds the key table, the scan pipeline and the result register.
  satl_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .TILE_SIZE   (TILE_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cmd         (cmd),
    .light_id    (light_id),
    .atlas_width (atlas_width),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .slot        (slot),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .tile_extent (tile_extent)
  );

endmodule

`default_nettype wire

### tb/sv/tb_shadow_atlas_tile_allocator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the shadow atlas tile allocator, with a small tile tracker class.
// Depends on satl_pkg and the shadow_atlas_tile_allocator RTL; needs nothing else.

module tb_shadow_atlas_tile_allocator;
  import satl_pkg::*;

  // Sizes the block is built with; the tracker uses the same numbers.
  localparam int N_ENTRIES = 16;
  localparam int KEY_W     = 32;
  localparam int TILE_PX   = 1024;

  // The command code that the block does not define.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 2;
  localparam int MAX_GAP     = 9;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 30;
  localparam int POOL_SIZE   = 20;
  localparam int PHASE_ITEMS = 172;
  localparam int N_PHASES    = 8;
  localparam int MAX_REPORTS = 40;
  // Roughly 1400 requests at the slowest correct pace come to about 0.65 ms.
  localparam int TIMEOUT_NS  = 6_000_000;

  // One result transfer as it appears on the output ports.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TILE_X_W-1:0] x;
    logic [TILE_Y_W-1:0] y;
    logic [EXT_W-1:0]    ext;
  } tile_grant_t;

  // The tracker mirrors the key table, its fill count and the atlas width.
  // Every accepted request is replayed on the mirror, and the grant it
  // should produce is queued; every result transfer is checked against the
  // head of that queue.
  class atlas_tile_tracker;
    logic [LIGHT_ID_W-1:0] keys [N_ENTRIES];
    int unsigned           used;
    logic [ATLAS_W-1:0]    width;
    tile_grant_t           tiles_due[$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           status_seen [4];

    function new();
      used    = 0;
      width   = ATLAS_RESET;
      errors  = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Adds a grant at the tail of the pending queue.
    function void queue_grant(tile_grant_t g);
      tiles_due.insert(tiles_due.size(), g);
    endfunction

    // Builds the grant for a slot; tiles only come with found or new slots.
    function tile_grant_t place(logic [STATUS_W-1:0] st, int unsigned pos, bit with_tile);
      tile_grant_t g;
      int unsigned cols;
      int unsigned v;
      cols = width / TILE_PX;
      if (cols == 0) cols = 1;
      g.status = st;
      g.slot   = '0;
      g.x      = '0;
      g.y      = '0;
      g.ext    = '0;
      if (with_tile) begin
        g.slot = pos[SLOT_W-1:0];
        v      = (pos % cols) * TILE_PX + TILE_PAD;
        g.x    = v[TILE_X_W-1:0];
        v      = (pos / cols) * TILE_PX + TILE_PAD;
        g.y    = v[TILE_Y_W-1:0];
        v      = TILE_PX - 2 * TILE_PAD;
        g.ext  = v[EXT_W-1:0];
      end
      return g;
    endfunction

    function void note_request(logic [CMD_W-1:0] c, logic [LIGHT_ID_W-1:0] id);
      int unsigned i;
      int unsigned w;
      int unsigned pos;
      bit hit;
      hit = 0;
      pos = 0;
      case (c)
        CMD_GET: begin
          for (i = 0; i < used; i++) begin
            if (!hit && keys[i] == id) begin
              hit = 1;
              pos = i;
            end
          end
          if (hit) begin
            queue_grant(place(ST_FOUND, pos, 1'b1));
          end else if (used >= N_ENTRIES) begin
            queue_grant(place(ST_FULL, 0, 1'b0));
          end else begin
            keys[used] = id;
            queue_grant(place(ST_NEW, used, 1'b1));
            used++;
          end
        end
        CMD_REL: begin
          // Drop every copy of the key and close the gaps in order.
          w = 0;
          for (i = 0; i < used; i++) begin
            if (keys[i] != id) begin
              keys[w] = keys[i];
              w++;
            end
          end
          used = w;
          queue_grant(place(ST_DONE, 0, 1'b0));
        end
        CMD_CLR: begin
          used = 0;
          queue_grant(place(ST_DONE, 0, 1'b0));
        end
        default: begin
          queue_grant(place(ST_DONE, 0, 1'b0));
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_grant(tile_grant_t got);
      tile_grant_t want;
      if (tiles_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request pending, expected none, actual status %0d slot %0d",
                   $time, got.status, got.slot);
        return;
      end
      want = tiles_due.pop_front();
      checked++;
      status_seen[got.status]++;
      compare_field("status", want.status, got.status);
      compare_field("slot", want.slot, got.slot);
      compare_field("tile_x", want.x, got.x);
      compare_field("tile_y", want.y, got.y);
      compare_field("tile_extent", want.ext, got.ext);
    endfunction
  endclass

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic [ATLAS_W-1:0]    cfg_wr_data = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd         = '0;
  logic [LIGHT_ID_W-1:0] light_id    = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_W-1:0]     slot;
  logic [TILE_X_W-1:0]   tile_x;
  logic [TILE_Y_W-1:0]   tile_y;
  logic [EXT_W-1:0]      tile_extent;

  atlas_tile_tracker tracker = new();

  // Shared controls of the two sides: idle_on turns the random waits on or
  // off, hold_req asks the receiver for one long stall.
  bit          idle_on      = 1'b1;
  bit          hold_req     = 1'b0;
  int unsigned n_sent       = 0;
  int unsigned n_in_stalled = 0;
  int unsigned n_widths     = 0;

  logic [LIGHT_ID_W-1:0] key_pool [POOL_SIZE];

  shadow_atlas_tile_allocator #(
    .MAX_ENTRIES (N_ENTRIES),
    .KEY_BITS    (KEY_W),
    .TILE_SIZE   (TILE_PX)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .light_id    (light_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot        (slot),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .tile_extent (tile_extent)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Offers one request after a random gap and holds it until the transfer.
  // All calls start at a rising edge, so in_valid is assigned only once per
  // time step: a gap of zero keeps it high straight into the next request.
  task automatic send_request(logic [CMD_W-1:0] c, logic [LIGHT_ID_W-1:0] id);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    light_id <= id;
    // Signals read right after the edge still hold their pre-edge values.
    do begin
      @(posedge clk);
      if (in_stall) n_in_stalled++;
    end while (in_stall);
    tracker.note_request(c, id);
    n_sent++;
  endtask

  // Withdraws the input, waits for every pending grant and lets the block
  // settle, so that the next register write finds it idle.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (tracker.tiles_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The write lands at the edge after it is set up; the block is idle then.
  task automatic write_width(logic [ATLAS_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    tracker.width  = v;
    n_widths++;
  endtask

  // Mostly lookups and releases drawn from a pool a little larger than the
  // table, so that hits, appends, full tables and compaction all come up
  // often; the rest is fresh keys, clears and the spare command code.
  task automatic random_phase(int n);
    int pick;
    logic [LIGHT_ID_W-1:0] id;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = $urandom;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      id   = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 58) begin
        send_request(CMD_GET, id);
      end else if (pick < 84) begin
        send_request(CMD_REL, ($urandom_range(0, 9) < 8) ? id : $urandom);
      end else if (pick < 93) begin
        send_request(CMD_GET, $urandom);
      end else if (pick < 97) begin
        send_request(CMD_CLR, $urandom);
      end else begin
        send_request(CMD_SPARE, $urandom);
      end
    end
  endtask

  // The receiver stalls a random number of cycles before each result, or
  // once on request for a long stretch of its own count, while the sender
  // keeps offering requests so that the block fills up and stalls its input.
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      begin
        tile_grant_t got;
        got.status = status;
        got.slot   = slot;
        got.x      = tile_x;
        got.y      = tile_y;
        got.ext    = tile_extent;
        tracker.check_grant(got);
      end
    end
  end

  initial begin
    logic [ATLAS_W-1:0] widths [N_PHASES];
    widths = '{15'd1024, 15'd16384, 15'h7FFF, 15'd0, 15'd700, 15'd4096, 15'd0, 15'd5000};
    // One setting is drawn at random each run.
    widths[6] = ATLAS_W'($urandom_range(0, 32767));

    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset width of four columns: both extreme keys,
    // a hit, the spare code, a release of a present and of an absent key,
    // then the table filled to the last slot and one lookup past full.
    send_request(CMD_GET, 32'h0000_0000);
    send_request(CMD_GET, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h0000_0000);
    send_request(CMD_SPARE, 32'hFFFF_FFFF);
    send_request(CMD_REL, 32'hFFFF_FFFF);
    send_request(CMD_REL, 32'h1234_5678);
    for (int k = 1; k < N_ENTRIES; k++) send_request(CMD_GET, 32'h1000_0000 + k * 32'h0101_0101);
    send_request(CMD_GET, 32'hDEAD_BEEF);
    send_request(CMD_GET, 32'h1000_0000 + 15 * 32'h0101_0101);
    send_request(CMD_CLR, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'hDEAD_BEEF);
    drain_and_settle();

    // Random phases, each under its own atlas width: one tile, sixteen
    // tiles, all ones (more columns than the table has slots), zero and a
    // width below one tile (a single column), and a few others.
    // One phase runs with no idling at all, another contains the long hold.
    for (int p = 0; p < N_PHASES; p++) begin
      write_width(widths[p]);
      idle_on = (p != 2);
      if (p == 5) hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
      drain_and_settle();
    end

    $display("Covered %0d requests over %0d atlas widths: %0d hits, %0d new tiles, %0d full.",
             n_sent, n_widths, tracker.status_seen[ST_FOUND], tracker.status_seen[ST_NEW],
             tracker.status_seen[ST_FULL]);
    $display("%0d releases, clears or spare codes; input held back on %0d cycles.",
             tracker.status_seen[ST_DONE], n_in_stalled);
    if (tracker.errors == 0 && tracker.tiles_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results still pending", tracker.tiles_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/satl_pkg.sv
hw/rtl/satl_ctrl.sv
hw/rtl/satl_datapath.sv
hw/rtl/shadow_atlas_tile_allocator.sv
tb/sv/tb_shadow_atlas_tile_allocator.sv
